### src/suit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suit_pkg
// Shared types and constants for the sorted unique insert table.
// ----------------------------------------------------------------------------
package suit_pkg;

  localparam int DEPTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DUMP   = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUMP      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic ins_step;
    logic dump_step;
  } suit_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_last;
  } suit_sts_t;

endpackage

### src/sorted_unique_insert_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_insert_table_top
// Bounded ascending set of signed 16-bit values with insert and dump.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one word of func_i and
// value_i. func insert places the value in sorted order in a row of
// compare-and-shift cells, or reports duplicate or full; func dump streams
// every stored value in ascending order, last_o on the final one, or a
// single empty word when nothing is stored.
// Output channel (out_valid_o / out_ready_i) carries data_o, status_o and
// last_o from one output register.
// An insert captures the word, then, once the output register is free, all
// cells compare and shift in parallel as the result is loaded into it.
// A dump steps through the dump index, one entry per cycle while the
// receiver takes each word; an empty dump yields its single empty word.
// One operation is in flight at a time; the next word is taken as soon as
// the previous result is loaded into the output register.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset clears the fill count, so the table starts empty; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_unique_insert_table_top import suit_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic [2:0]               status_o,
  output logic                     last_o
);

  suit_cmd_t cmd;
  suit_sts_t sts;

  suit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  suit_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

### src/suit_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suit_ctrl
// Sequencer for insert and dump operations of the sorted table.
// ----------------------------------------------------------------------------
module suit_ctrl import suit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      func_i,
  input  suit_sts_t sts_i,
  output suit_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    cmd_o.capture     = 1'b0;
    cmd_o.ins_step    = 1'b0;
    cmd_o.dump_step   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = (func_i == FUNC_DUMP) ? S_DUMP : S_INS;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins_step = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.dump_step = 1'b1;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/suit_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suit_datapath
// Row of compare-and-shift cells, fill count, dump index and output word.
// ----------------------------------------------------------------------------
module suit_datapath import suit_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] value_i,
  input  suit_cmd_t                cmd_i,
  output suit_sts_t                sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic [2:0]               status_o,
  output logic                     last_o
);

  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic signed [DATA_W-1:0] entries_d [DEPTH];
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [DATA_W-1:0] data_q;
  status_e                  status_q;
  logic                     last_q;
  logic                     out_valid_q;

  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] eq;
  logic             dup;
  logic             full;
  logic             empty;
  logic             idx_last;

  // per-cell compare against the captured value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (entries_q[i] < value_q);
      eq[i] = (CNT_W'(i) < count_q) && (entries_q[i] == value_q);
    end
  end

  assign dup      = |eq;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign idx_last = (idx_q == IDX_W'(count_q - CNT_W'(1)));

  // cells below the insert point keep, the insert point takes the value, cells above take their lower neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (lt[i]) begin
        entries_d[i] = entries_q[i];
      end else if (i > 0 && !lt[(i > 0) ? i - 1 : 0]) begin
        entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else begin
        entries_d[i] = value_q;
      end
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.dump_last = empty || idx_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= value_i;
    end
    if (cmd_i.ins_step && !dup && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      data_q      <= '0;
      status_q    <= ST_INSERTED;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end
      if (cmd_i.ins_step) begin
        out_valid_q <= 1'b1;
        data_q      <= '0;
        last_q      <= 1'b1;
        if (dup) begin
          status_q <= ST_DUPLICATE;
        end else if (full) begin
          status_q <= ST_FULL;
        end else begin
          status_q <= ST_INSERTED;
          count_q  <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.dump_step) begin
        out_valid_q <= 1'b1;
        if (empty) begin
          data_q   <= '0;
          status_q <= ST_EMPTY;
          last_q   <= 1'b1;
        end else begin
          data_q   <= entries_q[idx_q];
          status_q <= ST_DUMP;
          last_q   <= idx_last;
          idx_q    <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule
